>>> src/rtsp_pkg.sv
`default_nettype none

package rtsp_pkg;

   localparam int TILE_W       = 10;
   localparam int REF_W        = 16;
   localparam int STATUS_W     = 2;
   localparam int OUT_SLOT_W   = 6;
   localparam int KIND_W       = 2;
   localparam int SLOT_COUNT_W = 7;
   localparam int TILE_COUNT_W = 11;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 11;

   localparam logic [REF_W-1:0] REF_MAX = '1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_COUNT = 1'd1;

   localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 7'd64;
   localparam logic [TILE_COUNT_W-1:0] TILE_COUNT_RESET = 11'd1024;

   typedef enum logic [KIND_W-1:0] {
      KIND_ATTACH = 2'd0,
      KIND_DETACH = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              valid;
      logic              attach;
      logic [TILE_W-1:0] tile;
      logic              hit;
      logic              free_found;
      logic [REF_W-1:0]  refs;
   } token_type;

   typedef struct packed {
      logic              clear;
      logic              claim;
      logic [TILE_W-1:0] tile;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> src/rtsp_cell.sv
`default_nettype none

module rtsp_cell #(
   parameter int SLOT_W   = 6,
   parameter int CELL_IDX = 0
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [rtsp_pkg::SLOT_COUNT_W-1:0]     slot_count,
   input  wire rtsp_pkg::cell_cmd_type                cmd,
   input  wire logic [SLOT_W-1:0]                     claim_slot,
   input  wire rtsp_pkg::token_type                   up_tok,
   input  wire logic [SLOT_W-1:0]                     up_hit_slot,
   input  wire logic [SLOT_W-1:0]                     up_free_slot,
   output rtsp_pkg::token_type                        dn_tok,
   output logic [SLOT_W-1:0]                          dn_hit_slot,
   output logic [SLOT_W-1:0]                          dn_free_slot
);

   localparam int CW = (SLOT_W + 1 > rtsp_pkg::SLOT_COUNT_W) ? SLOT_W + 1
                                                              : rtsp_pkg::SLOT_COUNT_W;
   localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);
   localparam logic [CW-1:0]     MY_IDX_WIDE = CW'(CELL_IDX);

   logic                               used_ff, used_in;
   logic [rtsp_pkg::TILE_W-1:0]        owner_ff, owner_in;
   logic [rtsp_pkg::REF_W-1:0]         refs_ff, refs_in;
   rtsp_pkg::token_type                tok_ff, tok_in;
   logic [SLOT_W-1:0]                  hit_slot_ff, hit_slot_in;
   logic [SLOT_W-1:0]                  free_slot_ff, free_slot_in;
   logic                               match;
   logic                               in_range;

   assign match    = up_tok.valid && used_ff && !up_tok.hit && (owner_ff == up_tok.tile);
   assign in_range = MY_IDX_WIDE < CW'(slot_count);

   always_comb begin
      used_in      = used_ff;
      owner_in     = owner_ff;
      refs_in      = refs_ff;
      tok_in       = up_tok;
      hit_slot_in  = up_hit_slot;
      free_slot_in = up_free_slot;

      if (match) begin
         if (up_tok.attach) begin
            if (refs_ff != rtsp_pkg::REF_MAX) begin
               refs_in = rtsp_pkg::REF_W'(refs_ff + 1'b1);
            end
         end else if (refs_ff > rtsp_pkg::REF_W'(1)) begin
            refs_in = rtsp_pkg::REF_W'(refs_ff - 1'b1);
         end else begin
            refs_in = '0;
            used_in = 1'b0;
         end
         tok_in.hit  = 1'b1;
         tok_in.refs = refs_in;
         hit_slot_in = MY_IDX;
      end

      if (up_tok.valid && !used_ff && !up_tok.free_found && in_range) begin
         tok_in.free_found = 1'b1;
         free_slot_in      = MY_IDX;
      end

      if (cmd.clear) begin
         used_in = 1'b0;
      end else if (cmd.claim && (claim_slot == MY_IDX)) begin
         used_in  = 1'b1;
         owner_in = cmd.tile;
         refs_in  = rtsp_pkg::REF_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         used_ff <= used_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff          <= owner_in;
      refs_ff           <= refs_in;
      hit_slot_ff       <= hit_slot_in;
      free_slot_ff      <= free_slot_in;
   end

   assign dn_tok       = tok_ff;
   assign dn_hit_slot  = hit_slot_ff;
   assign dn_free_slot = free_slot_ff;

endmodule

`default_nettype wire

>>> src/refcounted_tile_slot_pool.sv
// Reference-counted pool of video-memory slots shared by tiles.
// The req channel carries one command per transfer: attach a tile, detach a
// tile, or clear the whole pool. The rsp channel returns exactly one result
// per command: a status, the reference count after the operation and the slot.
// Slot state lives in a row of NUM_SLOTS cells. An attach or detach sends a
// token down the row, one cell per cycle; each cell checks whether it owns the
// tile, updates its count in place and notes the lowest free slot in range.
// When the token leaves the last cell a new slot is claimed if one is needed.
// Attach and detach pass through the cell row, the result register and the
// output register before rsp_valid, so their delay is set by the length of
// the cell row; errors and clear skip the row and pass only through the
// result and output registers. One command is in flight at a time: a new req
// transfer is taken once the previous result sits in the output register, so
// a command runs while the receiver still holds off an earlier result.
// If rsp_ready stays low, the finished result waits in the block and
// req_ready stays low until the output register frees up.
// Synchronous reset empties every slot and sets slot_count to 64 and
// tile_count to 1024; the user must write these registers through the csr
// port only while idle, and the block itself does not enforce this.

`default_nettype none

module refcounted_tile_slot_pool #(
   parameter int NUM_SLOTS = 64,
   parameter int MAX_TILES = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                csr_wr_en,
   input  wire logic [rtsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rtsp_pkg::CSR_DATA_W-1:0]     csr_wdata,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [rtsp_pkg::KIND_W-1:0]         req_kind,
   input  wire logic [rtsp_pkg::TILE_W-1:0]         req_tile_index,
   input  wire logic                                req_tile_present,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [rtsp_pkg::STATUS_W-1:0]            rsp_status,
   output logic [rtsp_pkg::REF_W-1:0]               rsp_ref_count,
   output logic [rtsp_pkg::OUT_SLOT_W-1:0]          rsp_slot_index
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);

   rtsp_pkg::state_type                        state_ff, state_in;
   logic [rtsp_pkg::SLOT_COUNT_W-1:0]          slot_count_ff;
   logic [rtsp_pkg::TILE_COUNT_W-1:0]          tile_count_ff;

   logic [rtsp_pkg::STATUS_W-1:0]              res_status_ff, res_status_in;
   logic [rtsp_pkg::REF_W-1:0]                 res_refs_ff, res_refs_in;
   logic [SLOT_W-1:0]                          res_slot_ff, res_slot_in;

   logic                                       rsp_valid_ff, rsp_valid_in;
   logic [rtsp_pkg::STATUS_W-1:0]              rsp_status_ff;
   logic [rtsp_pkg::REF_W-1:0]                 rsp_refs_ff;
   logic [rtsp_pkg::OUT_SLOT_W-1:0]            rsp_slot_ff;
   logic [SLOT_W+rtsp_pkg::OUT_SLOT_W-1:0]     res_slot_wide;

   rtsp_pkg::token_type                        chain_tok [0:NUM_SLOTS];
   logic [SLOT_W-1:0]                          chain_hit_slot [0:NUM_SLOTS];
   logic [SLOT_W-1:0]                          chain_free_slot [0:NUM_SLOTS];
   logic [NUM_SLOTS-1:0]                       tok_valid;
   rtsp_pkg::token_type                        tail_tok;

   rtsp_pkg::cell_cmd_type                     cmd;
   logic [SLOT_W-1:0]                          claim_slot;

   logic                                       accept;
   logic                                       bad_tile;
   logic                                       launch;
   logic                                       load_rsp;

   assign accept   = req_valid && req_ready;
   assign tail_tok = chain_tok[NUM_SLOTS];
   assign bad_tile = ({1'b0, req_tile_index} >= tile_count_ff)
                  || (32'(req_tile_index) >= 32'(MAX_TILES))
                  || !req_tile_present;

   always_comb begin
      case (rtsp_pkg::kind_type'(req_kind))
         rtsp_pkg::KIND_ATTACH,
         rtsp_pkg::KIND_DETACH: launch = !bad_tile;
         default:               launch = 1'b0;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= rtsp_pkg::SLOT_COUNT_RESET;
         tile_count_ff <= rtsp_pkg::TILE_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            rtsp_pkg::CSR_SLOT_COUNT: slot_count_ff <= csr_wdata[rtsp_pkg::SLOT_COUNT_W-1:0];
            rtsp_pkg::CSR_TILE_COUNT: tile_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Token entering the first cell.
   always_comb begin
      chain_tok[0]            = '0;
      chain_tok[0].valid      = accept && launch;
      chain_tok[0].attach     = rtsp_pkg::kind_type'(req_kind) == rtsp_pkg::KIND_ATTACH;
      chain_tok[0].tile       = req_tile_index;
      chain_hit_slot[0]       = '0;
      chain_free_slot[0]      = '0;
   end

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      rtsp_cell #(
         .SLOT_W   (SLOT_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .slot_count   (slot_count_ff),
         .cmd          (cmd),
         .claim_slot   (claim_slot),
         .up_tok       (chain_tok[i]),
         .up_hit_slot  (chain_hit_slot[i]),
         .up_free_slot (chain_free_slot[i]),
         .dn_tok       (chain_tok[i+1]),
         .dn_hit_slot  (chain_hit_slot[i+1]),
         .dn_free_slot (chain_free_slot[i+1])
      );
      assign tok_valid[i] = chain_tok[i+1].valid;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtsp_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = launch ? rtsp_pkg::ST_SCAN : rtsp_pkg::ST_DONE;
            end
         end
         rtsp_pkg::ST_SCAN: begin
            if (tail_tok.valid) begin
               state_in = rtsp_pkg::ST_DONE;
            end
         end
         rtsp_pkg::ST_DONE: begin
            if (load_rsp) begin
               state_in = rtsp_pkg::ST_IDLE;
            end
         end
         default: state_in = rtsp_pkg::ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ready  = state_ff == rtsp_pkg::ST_IDLE;
      load_rsp   = (state_ff == rtsp_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      cmd.clear  = (state_ff == rtsp_pkg::ST_IDLE) && req_valid
                && (rtsp_pkg::kind_type'(req_kind) == rtsp_pkg::KIND_CLEAR);
      cmd.claim  = (state_ff == rtsp_pkg::ST_SCAN) && tail_tok.valid && tail_tok.attach
                && !tail_tok.hit && tail_tok.free_found;
      cmd.tile   = tail_tok.tile;
      claim_slot = chain_free_slot[NUM_SLOTS];
   end

   // Result of the command in flight.
   always_comb begin
      res_status_in = res_status_ff;
      res_refs_in   = res_refs_ff;
      res_slot_in   = res_slot_ff;
      if (accept && !launch) begin
         res_refs_in = '0;
         res_slot_in = '0;
         if (rtsp_pkg::kind_type'(req_kind) == rtsp_pkg::KIND_CLEAR) begin
            res_status_in = rtsp_pkg::STATUS_DONE;
         end else begin
            res_status_in = rtsp_pkg::STATUS_ERROR;
         end
      end else if ((state_ff == rtsp_pkg::ST_SCAN) && tail_tok.valid) begin
         if (tail_tok.hit) begin
            res_status_in = rtsp_pkg::STATUS_DONE;
            res_refs_in   = tail_tok.refs;
            res_slot_in   = chain_hit_slot[NUM_SLOTS];
         end else if (!tail_tok.attach) begin
            res_status_in = rtsp_pkg::STATUS_ERROR;
            res_refs_in   = '0;
            res_slot_in   = '0;
         end else if (tail_tok.free_found) begin
            res_status_in = rtsp_pkg::STATUS_DONE;
            res_refs_in   = rtsp_pkg::REF_W'(1);
            res_slot_in   = chain_free_slot[NUM_SLOTS];
         end else begin
            res_status_in = rtsp_pkg::STATUS_FULL;
            res_refs_in   = '0;
            res_slot_in   = '0;
         end
      end
   end

   assign res_slot_wide = {{rtsp_pkg::OUT_SLOT_W{1'b0}}, res_slot_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtsp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_refs_ff   <= res_refs_in;
      res_slot_ff   <= res_slot_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_refs_ff   <= res_refs_ff;
         rsp_slot_ff   <= res_slot_wide[rtsp_pkg::OUT_SLOT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_ref_count  = rsp_refs_ff;
   assign rsp_slot_index = rsp_slot_ff;

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid) <= 1)
      else $error("more than one token in the cell row");

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail_tok.valid |-> state_ff == rtsp_pkg::ST_SCAN)
      else $error("token left the cell row outside a scan");

   a_idle_row_empty: assert property (@(posedge clock) disable iff (reset)
      accept |-> tok_valid == '0)
      else $error("transfer accepted while a token is still in the row");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && state_ff == rtsp_pkg::ST_IDLE)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;

   localparam int POOL_SLOTS   = 64;
   localparam int TILE_SPACE   = 1024;
   localparam int DRAIN_CYCLES = POOL_SLOTS + 8;
   localparam int HOLD_CYCLES  = 600;
   localparam logic [rtsp_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [rtsp_pkg::STATUS_W-1:0]   status;
      logic [rtsp_pkg::REF_W-1:0]      refs;
      logic [rtsp_pkg::OUT_SLOT_W-1:0] slot;
   } pool_result_type;

   logic                              clock            = 1'b0;
   logic                              reset            = 1'b1;
   logic                              csr_wr_en        = 1'b0;
   logic [rtsp_pkg::CSR_IDX_W-1:0]    csr_index        = '0;
   logic [rtsp_pkg::CSR_DATA_W-1:0]   csr_wdata        = '0;
   logic                              req_valid        = 1'b0;
   logic                              req_ready;
   logic [rtsp_pkg::KIND_W-1:0]       req_kind         = '0;
   logic [rtsp_pkg::TILE_W-1:0]       req_tile_index   = '0;
   logic                              req_tile_present = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready        = 1'b0;
   logic [rtsp_pkg::STATUS_W-1:0]     rsp_status;
   logic [rtsp_pkg::REF_W-1:0]        rsp_ref_count;
   logic [rtsp_pkg::OUT_SLOT_W-1:0]   rsp_slot_index;

   logic                              slot_busy     [POOL_SLOTS];
   logic [rtsp_pkg::REF_W-1:0]        slot_refcnt   [POOL_SLOTS];
   logic                              tile_has_slot [TILE_SPACE];
   logic [rtsp_pkg::OUT_SLOT_W-1:0]   tile_home     [TILE_SPACE];
   logic [rtsp_pkg::SLOT_COUNT_W-1:0] active_slots;
   logic [rtsp_pkg::TILE_COUNT_W-1:0] valid_tiles;

   pool_result_type pending_results[$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 26;
   int              recv_idle_pct  = 79;
   logic            hold_active    = 1'b0;

   refcounted_tile_slot_pool #(
      .NUM_SLOTS(POOL_SLOTS),
      .MAX_TILES(TILE_SPACE)
   ) DUT (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void empty_pool();
      for (int i = 0; i < POOL_SLOTS; i++) begin
         slot_busy[i]   = 1'b0;
         slot_refcnt[i] = '0;
      end
      for (int t = 0; t < TILE_SPACE; t++) begin
         tile_has_slot[t] = 1'b0;
         tile_home[t]     = '0;
      end
   endfunction

   function automatic pool_result_type predict_pool_result(
         input logic [rtsp_pkg::KIND_W-1:0] kind,
         input logic [rtsp_pkg::TILE_W-1:0] tile,
         input logic present);
      pool_result_type res;
      int slot_limit;
      int s;
      res.status = rtsp_pkg::STATUS_ERROR;
      res.refs   = '0;
      res.slot   = '0;
      slot_limit = (active_slots < POOL_SLOTS) ? active_slots : POOL_SLOTS;
      s = -1;
      if (kind == rtsp_pkg::KIND_CLEAR) begin
         empty_pool();
         res.status = rtsp_pkg::STATUS_DONE;
      end else if ((kind != rtsp_pkg::KIND_ATTACH && kind != rtsp_pkg::KIND_DETACH)
                   || !present || tile >= valid_tiles) begin
         res.status = rtsp_pkg::STATUS_ERROR;
      end else if (tile_has_slot[tile]) begin
         s = tile_home[tile];
         if (kind == rtsp_pkg::KIND_ATTACH) begin
            if (slot_refcnt[s] != rtsp_pkg::REF_MAX) slot_refcnt[s] = slot_refcnt[s] + 1'b1;
         end else if (slot_refcnt[s] > 1) begin
            slot_refcnt[s] = slot_refcnt[s] - 1'b1;
         end else begin
            slot_busy[s]        = 1'b0;
            slot_refcnt[s]      = '0;
            tile_has_slot[tile] = 1'b0;
         end
         res.status = rtsp_pkg::STATUS_DONE;
         res.refs   = slot_refcnt[s];
         res.slot   = rtsp_pkg::OUT_SLOT_W'(s);
      end else if (kind == rtsp_pkg::KIND_ATTACH) begin
         for (int i = slot_limit - 1; i >= 0; i--) begin
            if (!slot_busy[i]) s = i;
         end
         if (s < 0) begin
            res.status = rtsp_pkg::STATUS_FULL;
         end else begin
            slot_busy[s]        = 1'b1;
            slot_refcnt[s]      = 16'd1;
            tile_has_slot[tile] = 1'b1;
            tile_home[tile]     = rtsp_pkg::OUT_SLOT_W'(s);
            res.status = rtsp_pkg::STATUS_DONE;
            res.refs   = 16'd1;
            res.slot   = rtsp_pkg::OUT_SLOT_W'(s);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      pool_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with no command outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            if (rsp_ref_count !== want.refs)
               report_mismatch($sformatf("ref_count %0d, expected %0d",
                                         rsp_ref_count, want.refs));
            if (rsp_slot_index !== want.slot)
               report_mismatch($sformatf("slot_index %0d, expected %0d",
                                         rsp_slot_index, want.slot));
         end
      end
   end

   task automatic send_command(input logic [rtsp_pkg::KIND_W-1:0] kind,
                               input logic [rtsp_pkg::TILE_W-1:0] tile,
                               input logic present);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_tile_index   <= tile;
      req_tile_present <= present;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_pool_result(kind, tile, present));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [rtsp_pkg::CSR_IDX_W-1:0] index,
                                 input int value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= rtsp_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == rtsp_pkg::CSR_SLOT_COUNT) active_slots = rtsp_pkg::SLOT_COUNT_W'(value);
      else valid_tiles = rtsp_pkg::TILE_COUNT_W'(value);
      @(posedge clock);
   endtask

   task automatic configure_pool(input int slots, input int tiles);
      wait_for_results();
      write_register(rtsp_pkg::CSR_SLOT_COUNT, slots);
      write_register(rtsp_pkg::CSR_TILE_COUNT, tiles);
   endtask

   // Most tiles come from a window of 96 so that tiles repeat, share slots and fill the pool.
   task automatic send_random_commands(input int count, input int tile_base);
      logic [rtsp_pkg::KIND_W-1:0] kind;
      logic [rtsp_pkg::TILE_W-1:0] tile;
      logic                        present;
      int                          pick;
      repeat (count) begin
         pick = $urandom_range(999);
         if (pick < 5) kind = rtsp_pkg::KIND_CLEAR;
         else if (pick < 15) kind = KIND_UNKNOWN;
         else if (pick < 600) kind = rtsp_pkg::KIND_ATTACH;
         else kind = rtsp_pkg::KIND_DETACH;
         if ($urandom_range(9) == 0)
            tile = rtsp_pkg::TILE_W'($urandom_range(TILE_SPACE - 1));
         else
            tile = rtsp_pkg::TILE_W'(tile_base + $urandom_range(95));
         present = ($urandom_range(29) != 0);
         send_command(kind, tile, present);
      end
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct,
                                   input int slots, input int tiles, input int count);
      configure_pool(slots, tiles);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      send_random_commands(count, $urandom_range(TILE_SPACE - 1));
   endtask

   task automatic test_attach_detach_basics();
      send_command(rtsp_pkg::KIND_ATTACH, 10'd0, 1'b1);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd1023, 1'b1);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd0, 1'b1);
      send_command(rtsp_pkg::KIND_DETACH, 10'd0, 1'b1);
      send_command(rtsp_pkg::KIND_DETACH, 10'd0, 1'b1);
      send_command(rtsp_pkg::KIND_DETACH, 10'd0, 1'b1);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd5, 1'b0);
      send_command(rtsp_pkg::KIND_DETACH, 10'd1023, 1'b0);
      send_command(KIND_UNKNOWN, 10'd1023, 1'b1);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd682, 1'b1);
      send_command(rtsp_pkg::KIND_CLEAR, 10'd341, 1'b0);
      send_command(rtsp_pkg::KIND_DETACH, 10'd682, 1'b1);
   endtask

   // Tiles that already sit above a reduced slot count must still be served.
   task automatic test_shrunk_slot_count();
      for (int t = 100; t < 105; t++)
         send_command(rtsp_pkg::KIND_ATTACH, rtsp_pkg::TILE_W'(t), 1'b1);
      configure_pool(3, TILE_SPACE);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd104, 1'b1);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd200, 1'b1);
      send_command(rtsp_pkg::KIND_DETACH, 10'd101, 1'b1);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd200, 1'b1);
      configure_pool(3, 101);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd101, 1'b1);
      send_command(rtsp_pkg::KIND_DETACH, 10'd100, 1'b1);
   endtask

   task automatic test_register_extremes();
      configure_pool(0, TILE_SPACE);
      send_command(rtsp_pkg::KIND_CLEAR, 10'd0, 1'b1);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd7, 1'b1);
      configure_pool(127, 0);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd0, 1'b1);
      configure_pool(127, 2047);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd1023, 1'b1);
      configure_pool(2, 2047);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd1, 1'b1);
      send_command(rtsp_pkg::KIND_ATTACH, 10'd2, 1'b1);
   endtask

   task automatic test_random_traffic();
      run_random_phase(26, 79, 64, 1024, 300);
      run_random_phase(26, 79, 127, 2047, 250);
      run_random_phase(79, 26, 33, 700, 250);
      run_random_phase(79, 26, 1, 1024, 150);
      run_random_phase(0, 0, 64, 1024, 300);
      run_random_phase(0, 0, 127, 1024, 300);
   endtask

   // The receiver stops for a long stretch while commands keep coming, so the block backs up.
   task automatic test_receiver_hold_off();
      configure_pool(64, 1024);
      fork
         begin
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end
      join_none
      send_random_commands(30, $urandom_range(TILE_SPACE - 1));
   endtask

   initial begin
      empty_pool();
      active_slots = rtsp_pkg::SLOT_COUNT_RESET;
      valid_tiles  = rtsp_pkg::TILE_COUNT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_attach_detach_basics();
      test_shrunk_slot_count();
      test_register_extremes();
      test_random_traffic();
      test_receiver_hold_off();
      wait_for_results();
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
src/rtsp_pkg.sv
src/rtsp_cell.sv
src/refcounted_tile_slot_pool.sv
tb/tb_top.sv
